[sv/asds_pkg.sv]
// ----------------------------------------------------------------------------
// asds_pkg: shared types and constants
// word layouts, sort key and cell link types for the sweep scheduler
// ----------------------------------------------------------------------------
package asds_pkg;

    localparam int FIELD_W         = 30;
    localparam int KEY_W           = 2 * FIELD_W;
    localparam int TIME_W          = 32;
    localparam int SVC_W           = 16;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [SVC_W-1:0] SVC_RESET = SVC_W'(5);

    typedef enum logic
    {
        REQ_ENQUEUE = 1'b0,
        REQ_SWEEP   = 1'b1
    } req_type_t;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [FIELD_W-1:0] field_t;

    // input word
    typedef struct packed
    {
        req_type_t   req_type;
        field_t      location;
        field_t      process_id;
    } req_word_t;

    // result word
    typedef struct packed
    {
        logic [TIME_W-1:0] finish_time;
        field_t            served_process;
        field_t            served_location;
        logic              last;
        logic              overflow;
    } rsp_word_t;

    // what one cell shows its neighbors
    typedef struct packed
    {
        logic valid;
        logic beats;
        key_t key;
    } cell_link_t;

    // broadcast to every cell of the row
    typedef struct packed
    {
        logic insert;
        logic pop;
        logic ascending;
    } cell_ctl_t;

endpackage

[sv/alternating_sweep_disk_scheduler_top.sv]
// ----------------------------------------------------------------------------
// alternating_sweep_disk_scheduler_top: batch sweep disk request scheduler
// stores requests in a sorted cell row and drains them per sweep,
// alternating descending and ascending order
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  meaning
//  req       req_valid req_stall req_word     in         enqueue or sweep word
//  rsp       rsp_valid rsp_stall rsp_word     out        one word per served request
//  cfg       cfg_wr_en cfg_wr_data            in         service time per request
//
//  the row sorts an enqueue word in place as it lands
//  a sweep of n stored requests pops cell 0 n times, one pop per cycle while
//  rsp is not stalled, set by the single pop path of the cell row; req is stalled meanwhile
//  an empty sweep only flips the order
//  rsp stall holds the output register and pauses the pops
//  reset clears valid bits, counters, the clock and the overflow flag; no
//  clearing pass is needed
//
module alternating_sweep_disk_scheduler_top
    import asds_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_word_t        req_word,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_word_t        rsp_word,
    input  logic             cfg_wr_en,
    input  logic [SVC_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic
    {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ascending_reg;
    logic              ascending_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [SVC_W-1:0]  svc_reg;
    logic [SVC_W-1:0]  svc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_word_t         out_word_reg;
    rsp_word_t         out_word_next;

    logic      req_fire;
    logic      out_free;
    logic      pop;
    cell_ctl_t ctl;
    key_t      new_key;
    key_t      head_key;

    // no new word while a sweep is draining
    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;

    // output register can take a word this cycle
    assign out_free = !out_valid_reg || !rsp_stall;
    assign pop      = (state_reg == ST_DRAIN) && out_free;

    // sort key: location above process id
    assign new_key = {req_word.location, req_word.process_id};

    assign ctl.insert    = req_fire && (req_word.req_type == REQ_ENQUEUE) &&
                           (count_reg != CNT_FULL);
    assign ctl.pop       = pop;
    assign ctl.ascending = ascending_reg;

    asds_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chain
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .new_key  (new_key),
        .head_key (head_key)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ascending_next = ascending_reg;
        time_next      = time_reg;
        dropped_next   = dropped_reg;
        svc_next       = svc_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_word_next  = out_word_reg;

        // to be written only while idle; the block itself does not enforce this
        if (cfg_wr_en)
        begin
            svc_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_word.req_type == REQ_ENQUEUE)
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // empty sweep only flips the order
                        ascending_next = !ascending_reg;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (pop)
                begin
                    time_next                     = time_reg + TIME_W'(svc_reg);
                    out_valid_next                = 1'b1;
                    out_word_next.finish_time     = time_reg + TIME_W'(svc_reg);
                    out_word_next.served_process  = head_key[FIELD_W-1:0];
                    out_word_next.served_location = head_key[KEY_W-1:FIELD_W];
                    out_word_next.last            = (count_reg == CNT_ONE);
                    out_word_next.overflow        = dropped_reg;
                    count_next                    = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        state_next     = ST_IDLE;
                        ascending_next = !ascending_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ascending_reg <= 1'b0;
            time_reg      <= '0;
            dropped_reg   <= 1'b0;
            svc_reg       <= SVC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ascending_reg <= ascending_next;
            time_reg      <= time_next;
            dropped_reg   <= dropped_next;
            svc_reg       <= svc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

[sv/asds_cell.sv]
// ----------------------------------------------------------------------------
// asds_cell: one slot of the sorted row
// holds one key, makes room on insert, takes its right neighbor on pop
// ----------------------------------------------------------------------------
module asds_cell
    import asds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  key_t       new_key,
    input  cell_link_t left,
    input  cell_link_t right,
    output cell_link_t self
);

    logic valid_reg;
    logic valid_next;
    key_t key_reg;
    key_t key_next;
    logic beats;

    // new key goes before this slot's key in the current order
    assign beats = !valid_reg ||
                   (ctl.ascending ? (key_reg > new_key) : (key_reg < new_key));

    assign self.valid = valid_reg;
    assign self.beats = beats;
    assign self.key   = key_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        if (ctl.pop)
        begin
            valid_next = right.valid;
            key_next   = right.key;
        end
        // an empty slot only fills when the slot to its left holds a key
        else if (ctl.insert && beats && left.valid)
        begin
            valid_next = 1'b1;
            key_next   = left.beats ? left.key : new_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

[sv/asds_chain.sv]
// ----------------------------------------------------------------------------
// asds_chain: row of sort cells
// keeps the stored keys sorted from cell 0, head of the row is the next key
// ----------------------------------------------------------------------------
module asds_chain
    import asds_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  key_t      new_key,
    output key_t      head_key
);

    cell_link_t links [QUEUE_DEPTH];
    cell_link_t lefts [QUEUE_DEPTH];
    cell_link_t rights[QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                // head sees a filled neighbor that never beats the new key
                assign lefts[i] = '{valid: 1'b1, beats: 1'b0, key: '0};
            end
            else
            begin : g_mid_l
                assign lefts[i] = links[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_end
                assign rights[i] = '0;
            end
            else
            begin : g_mid_r
                assign rights[i] = links[i+1];
            end

            asds_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .new_key (new_key),
                .left    (lefts[i]),
                .right   (rights[i]),
                .self    (links[i])
            );
        end
    endgenerate

    assign head_key = links[0].key;

endmodule

[sv/asds_checker.sv]
// ----------------------------------------------------------------------------
// asds_checker: port level checks
// sweep framing, drain flow and sticky overflow seen at the top level ports
// ----------------------------------------------------------------------------
module asds_checker
    import asds_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_stall,
    input req_word_t        req_word,
    input logic             rsp_valid,
    input logic             rsp_stall,
    input rsp_word_t        rsp_word
);

    // stalled input word holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
        else $error("stalled input word changed");

    // stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled result word changed");

    // mid-sweep the input stays stalled
    a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.last |-> req_stall)
        else $error("input open during a sweep");

    // next word of the sweep follows at once
    a_drain_flow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !rsp_word.last |=> rsp_valid)
        else $error("gap inside a sweep");

    // overflow stays set until reset
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && $past(rsp_valid && rsp_word.overflow) |-> rsp_word.overflow)
        else $error("overflow flag cleared");

endmodule

bind alternating_sweep_disk_scheduler_top asds_checker u_asds_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_word    (req_word),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_word    (rsp_word)
);
